// ===== rtl/core/u2u8_pkg.sv =====
// Shared types and constants for the UCS-2 to UTF-8 bounded encoder.
package u2u8_pkg;

  localparam logic [15:0] BUF_SIZE_RESET = 16'd256;
  localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
  localparam logic [7:0]  LEAD_TWO       = 8'hC0;
  localparam logic [7:0]  LEAD_THREE     = 8'hE0;
  localparam logic [7:0]  CONT_MARK      = 8'h80;
  localparam logic [5:0]  CONT_MASK      = 6'd63;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0][7:0] utf8;
    logic [1:0]      nb;
    logic            term;
    logic [15:0]     cnt;
  } job_t;

endpackage

// ===== rtl/core/u2u8_if.sv =====
// Valid/ready channel interfaces for code units and encoded bytes.
interface u2u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        first_of_string;

  modport source (output valid, code_unit, first_of_string, input ready);
  modport sink (input valid, code_unit, first_of_string, output ready);
endinterface

interface u2u8_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_terminator;
  logic [15:0] byte_count;
  logic        last_of_run;

  modport source (output valid, out_byte, is_terminator, byte_count, last_of_run,
                  input ready);
  modport sink (input valid, out_byte, is_terminator, byte_count, last_of_run,
                output ready);
endinterface

// ===== rtl/core/u2u8_front.sv =====
// Front end: accepts code units, tracks the string budget and builds byte jobs.
module u2u8_front
  import u2u8_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  u2u8_in_if.sink     in_ch,
  input  logic        q_full,
  output logic        push,
  output job_t        push_job
);

  logic [15:0] buf_size_r;
  logic [15:0] bytes_written_r, bytes_written_nxt;
  logic        string_done_r, string_done_nxt;

  logic        accept;
  logic [15:0] bw_eff;
  logic        done_eff;
  logic [15:0] budget;
  logic [15:0] cu;
  logic [1:0]  nb;
  logic [2:0][7:0] utf8;
  logic [16:0] sum;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cu          = in_ch.code_unit;
  assign bw_eff      = in_ch.first_of_string ? 16'd0 : bytes_written_r;
  assign done_eff    = in_ch.first_of_string ? 1'b0 : string_done_r;
  assign budget      = buf_size_r - 16'd1;
  assign sum         = {1'b0, bw_eff} + {15'd0, nb};

  always_comb begin
    utf8 = '0;
    if (cu < ONE_BYTE_LIMIT) begin
      nb      = 2'd1;
      utf8[0] = cu[7:0];
    end else if (cu < TWO_BYTE_LIMIT) begin
      nb      = 2'd2;
      utf8[0] = LEAD_TWO | {3'd0, cu[10:6]};
      utf8[1] = CONT_MARK | {2'd0, cu[5:0] & CONT_MASK};
    end else begin
      nb      = 2'd3;
      utf8[0] = LEAD_THREE | {4'd0, cu[15:12]};
      utf8[1] = CONT_MARK | {2'd0, cu[11:6] & CONT_MASK};
      utf8[2] = CONT_MARK | {2'd0, cu[5:0] & CONT_MASK};
    end
  end

  always_comb begin
    push              = 1'b0;
    push_job.utf8     = utf8;
    push_job.nb       = 2'd0;
    push_job.term     = 1'b0;
    push_job.cnt      = bw_eff;
    bytes_written_nxt = bw_eff;
    string_done_nxt   = done_eff;
    if (!done_eff) begin
      if (buf_size_r == 16'd0) begin
        string_done_nxt = 1'b1;
      end else if (bw_eff >= budget || cu == 16'd0) begin
        push            = accept;
        push_job.term   = 1'b1;
        string_done_nxt = 1'b1;
      end else if (sum > {1'b0, budget}) begin
        push            = accept;
        push_job.term   = 1'b1;
        string_done_nxt = 1'b1;
      end else begin
        push              = accept;
        push_job.nb       = nb;
        push_job.cnt      = sum[15:0];
        bytes_written_nxt = sum[15:0];
        if (sum[15:0] >= budget) begin
          push_job.term   = 1'b1;
          string_done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r      <= BUF_SIZE_RESET;
      bytes_written_r <= 16'd0;
      string_done_r   <= 1'b1;
    end else begin
      if (cfg_we) begin
        buf_size_r <= cfg_wdata;
      end
      if (accept) begin
        bytes_written_r <= bytes_written_nxt;
        string_done_r   <= string_done_nxt;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_job_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_job.nb != 2'd0 || push_job.term))
    else $error("front pushed a job with no results");
`endif

endmodule

// ===== rtl/core/u2u8_fifo.sv =====
// Short job queue between the front end and the byte emitter.
module u2u8_fifo
  import u2u8_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic full,
  output logic empty
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |-> !push)
    else $error("job queue written while full");
`endif

endmodule

// ===== rtl/core/u2u8_back.sv =====
// Back end: takes jobs from the queue and emits their bytes and terminator.
module u2u8_back
  import u2u8_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  job_t        head_job,
  input  logic        q_empty,
  output logic        pop,
  u2u8_out_if.source  out_ch
);

  job_t       job_r;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic       is_byte;
  logic       last;
  logic       xfer;
  logic [7:0] sel_byte;

  assign total   = {1'b0, job_r.nb} + {2'd0, job_r.term};
  assign is_byte = idx_r < job_r.nb;
  assign last    = ({1'b0, idx_r} + 3'd1) == total;
  assign xfer    = out_ch.valid && out_ch.ready;
  assign pop     = !q_empty && (!busy_r || (xfer && last));

  always_comb begin
    unique case (idx_r)
      2'd0:    sel_byte = job_r.utf8[0];
      2'd1:    sel_byte = job_r.utf8[1];
      2'd2:    sel_byte = job_r.utf8[2];
      default: sel_byte = 8'd0;
    endcase
  end

  assign out_ch.valid         = busy_r;
  assign out_ch.out_byte      = is_byte ? sel_byte : 8'd0;
  assign out_ch.is_terminator = !is_byte;
  assign out_ch.byte_count    = is_byte ? 16'd0 : job_r.cnt;
  assign out_ch.last_of_run   = last;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end else if (xfer) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ({1'b0, idx_r} < total))
    else $error("emitter index ran past the end of its job");
  a_term_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !is_byte) |-> last)
    else $error("terminator is not the last result of its unit");
`endif

endmodule

// ===== rtl/core/ucs2_to_utf8_bounded_encoder_top.sv =====
// Top level of the UCS-2 to UTF-8 encoder with a per-string byte budget.
// The front end takes one code unit per cycle whenever the two-entry job queue
// has room, and the back end emits one result per cycle while the output is
// ready: a unit yields up to four results (up to three UTF-8 bytes plus the
// terminator that ends a string), and a unit that is ignored after its string
// has ended yields none, so the sustained rate is set by the output port.
// The buffer size register is written through cfg_we and cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
module ucs2_to_utf8_bounded_encoder_top
  import u2u8_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  u2u8_in_if.sink     in_ch,
  u2u8_out_if.source  out_ch
);

  logic push;
  job_t push_job;
  logic pop;
  job_t head_job;
  logic q_full;
  logic q_empty;

  u2u8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  u2u8_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  u2u8_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// ===== dv/tb.sv =====
// Testbench for the UCS-2 to UTF-8 bounded encoder, checked against a predictor.
typedef struct packed {
  logic [7:0]  data;
  logic        term;
  logic [15:0] count;
  logic        last;
} utf8_result_t;

class utf8_scoreboard;
  logic [15:0]  buffer_size;
  logic [15:0]  bytes_written;
  bit           string_done;
  utf8_result_t pending_bytes[$];
  int unsigned  mismatches;
  int unsigned  units_seen;
  int unsigned  units_encoded;
  int unsigned  bytes_checked;
  int unsigned  terminators_checked;

  function new();
    buffer_size = u2u8_pkg::BUF_SIZE_RESET;
    bytes_written = '0;
    string_done = 1'b1;
    mismatches = 0;
    units_seen = 0;
    units_encoded = 0;
    bytes_checked = 0;
    terminators_checked = 0;
  endfunction

  function void set_buffer_size(logic [15:0] value);
    buffer_size = value;
  endfunction

  // Works out the bytes that one accepted code unit should produce.
  function void note_unit(logic [15:0] unit, logic first);
    logic [7:0]   enc [0:2];
    utf8_result_t res [0:3];
    int           nb;
    int           k;
    int           budget;
    bit           ends;
    k = 0;
    nb = 0;
    ends = 1'b0;
    units_seen++;
    if (first) begin
      bytes_written = '0;
      string_done = 1'b0;
    end
    if (string_done) return;
    if (buffer_size == 16'd0) begin
      string_done = 1'b1;
      return;
    end
    budget = int'(buffer_size) - 1;
    if (int'(bytes_written) >= budget || unit == 16'd0) begin
      ends = 1'b1;
    end else begin
      if (unit < u2u8_pkg::ONE_BYTE_LIMIT) begin
        nb = 1;
        enc[0] = unit[7:0];
      end else if (unit < u2u8_pkg::TWO_BYTE_LIMIT) begin
        nb = 2;
        enc[0] = u2u8_pkg::LEAD_TWO | {3'b000, unit[10:6]};
        enc[1] = u2u8_pkg::CONT_MARK | {2'b00, unit[5:0] & u2u8_pkg::CONT_MASK};
      end else begin
        nb = 3;
        enc[0] = u2u8_pkg::LEAD_THREE | {4'b0000, unit[15:12]};
        enc[1] = u2u8_pkg::CONT_MARK | {2'b00, unit[11:6] & u2u8_pkg::CONT_MASK};
        enc[2] = u2u8_pkg::CONT_MARK | {2'b00, unit[5:0] & u2u8_pkg::CONT_MASK};
      end
      if (int'(bytes_written) + nb > budget) begin
        ends = 1'b1;
      end else begin
        for (int i = 0; i < nb; i++) begin
          res[k] = '{data: enc[i], term: 1'b0, count: 16'd0, last: 1'b0};
          k++;
        end
        bytes_written = bytes_written + 16'(nb);
        if (int'(bytes_written) >= budget) ends = 1'b1;
      end
    end
    if (ends) begin
      res[k] = '{data: 8'h00, term: 1'b1, count: bytes_written, last: 1'b0};
      k++;
      string_done = 1'b1;
    end
    if (k > 0) begin
      res[k - 1].last = 1'b1;
      units_encoded++;
    end
    for (int i = 0; i < k; i++) pending_bytes.push_back(res[i]);
  endfunction

  function void check_result(logic [7:0] data, logic term, logic [15:0] count, logic last);
    utf8_result_t want;
    bytes_checked++;
    if (term) terminators_checked++;
    if (pending_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected byte %02h term %0b count %0d last %0b", data, term, count, last);
      return;
    end
    want = pending_bytes.pop_front();
    if (data !== want.data || term !== want.term || count !== want.count ||
        last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected byte %02h term %0b count %0d last %0b, ",
                 want.data, want.term, want.count, want.last,
                 "got byte %02h term %0b count %0d last %0b",
                 data, term, count, last);
    end
  endfunction
endclass

module tb;
  import u2u8_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic [15:0] stall_pat;
  logic [3:0]  stall_pos = '0;
  int          burst_left = 0;
  int          settings_used = 0;
  int unsigned random_goal;

  utf8_scoreboard sb = new();

  u2u8_in_if  in_ch();
  u2u8_out_if out_ch();

  ucs2_to_utf8_bounded_encoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_unit(in_ch.code_unit, in_ch.first_of_string);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.out_byte, out_ch.is_terminator, out_ch.byte_count,
                        out_ch.last_of_run);
    end
  end

  always @(posedge clk) begin
    if (stall_pos == 4'd0) begin
      case ($urandom_range(0, 3))
        0: begin
          stall_pat = 16'h0000;
        end
        1: begin
          stall_pat = 16'($urandom());
        end
        2: begin
          stall_pat = 16'hFFF0;
        end
        default: begin
          stall_pat = 16'h5555;
        end
      endcase
    end
    out_ch.ready <= ~stall_pat[stall_pos];
    stall_pos = stall_pos + 4'd1;
  end

  initial begin
    #2400000;
    $display("status: fail");
    $finish;
  end

  task automatic send_unit(input logic [15:0] unit, input logic first);
    in_ch.valid <= 1'b1;
    in_ch.code_unit <= unit;
    in_ch.first_of_string <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_buffer_size(input logic [15:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_buffer_size(value);
    settings_used++;
  endtask

  function automatic logic [15:0] pick_unit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'h0000;
    if (r < 30) return 16'($urandom_range(16'h0001, 16'h007F));
    if (r < 55) return 16'($urandom_range(16'h0080, 16'h07FF));
    if (r < 70) return 16'($urandom_range(16'hD800, 16'hDFFF));
    if (r < 90) return 16'($urandom_range(16'h0800, 16'hFFFF));
    return 16'($urandom());
  endfunction

  initial begin
    int          phase;
    int unsigned sent;
    logic [15:0] size_now;
    logic [15:0] sizes [0:8];
    logic        first;
    sizes = '{16'd65535, 16'd2, 16'd3, 16'd7, 16'd16, 16'd256, 16'd0, 16'd5, 16'd40};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.code_unit = '0;
    in_ch.first_of_string = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_unit(16'h0041, 1'b0);
    send_unit(16'h0000, 1'b1);
    send_unit(16'h0041, 1'b1);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'h0001, 1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(16'h1234, 1'b0);
    write_buffer_size(16'd0);
    send_unit(16'h0041, 1'b1);
    send_unit(16'h0042, 1'b0);
    write_buffer_size(16'd1);
    send_unit(16'h0041, 1'b1);
    send_unit(16'h0043, 1'b0);
    write_buffer_size(16'd4);
    send_unit(16'h0041, 1'b1);
    send_unit(16'h0800, 1'b0);
    send_unit(16'h0800, 1'b1);
    send_unit(16'h07FF, 1'b1);
    send_unit(16'h0041, 1'b0);
    write_buffer_size(16'd10);
    send_unit(16'h0800, 1'b1);
    send_unit(16'hABCD, 1'b0);
    // Lowering the size mid-string leaves the count already past the new budget.
    write_buffer_size(16'd3);
    send_unit(16'h0041, 1'b0);

    random_goal = 144;
    sent = 0;
    phase = 0;
    while (sent < random_goal) begin
      if (phase < 9) size_now = sizes[phase];
      else if ($urandom_range(0, 9) == 0) size_now = 16'd65535;
      else size_now = 16'($urandom_range(1, 64));
      write_buffer_size(size_now);
      for (int i = 0; i < 16; i++) begin
        if (sb.string_done) first = ($urandom_range(0, 9) != 0);
        else first = ($urandom_range(0, 29) == 0);
        send_unit(pick_unit(), first);
        sent++;
        if ($urandom_range(0, 39) == 0) drain();
      end
      phase++;
    end

    drain();
    $display("Fed %0d code units, %0d of them producing output, over %0d buffer sizes.",
             sb.units_seen, sb.units_encoded, settings_used);
    $display("Checked %0d output bytes, %0d of them string terminators.",
             sb.bytes_checked, sb.terminators_checked);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
